>>> rtl/core/lidg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidg_pkg
// Shared widths, codes and types of the led pixel interpolation, gamma and
// dither block.
// ----------------------------------------------------------------------------
package lidg_pkg;

    localparam int MAX_PIXELS   = 8192;
    localparam int ADDR_W       = $clog2(MAX_PIXELS);
    localparam int INDEX_W      = 13;
    localparam int COLOR_W      = 8;
    localparam int PROGRESS_W   = 16;
    localparam int LEVEL_W      = 16;
    localparam int FRAME_W      = 8;
    localparam int MAX_FRAMES_W = 15;
    localparam int WORD_W       = 32;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 40;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_DITHER_ENABLE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DITHER_FRAMES = 1'b1;

    localparam logic                    DITHER_ENABLE_RST     = 1'b1;
    localparam logic [MAX_FRAMES_W-1:0] MAX_DITHER_FRAMES_RST = 15'd8;

    // slope of the last curve segment, 0xffff - 255 * 255
    localparam logic [8:0] LAST_SLOPE = 9'd510;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [INDEX_W-1:0]          index;
        logic [FRAME_W-1:0]          frame;
        logic [2:0][LEVEL_W-1:0]     level;
    } job_t;

    typedef struct packed {
        logic [INDEX_W-1:0]          index;
        logic [2:0][COLOR_W-1:0]     color;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/led_pixel_interp_gamma_dither_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_interp_gamma_dither_top
// Frame interpolation, square-law correction and temporal dithering of an
// LED pixel stream, with per-pixel dither error memory.
// ----------------------------------------------------------------------------
// the back part works on one pixel at a time through the dither memory
//   read-modify-write sequence (read, age test, three channels, write)
// reset: s_tready stays low while the dither memory is cleared;
//   frame counter 0, dither_enable 1, max_dither_frames 8
// ----------------------------------------------------------------------------
module led_pixel_interp_gamma_dither_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lidg_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [lidg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_index[12:0], progress[28:13], prev_red[36:29], prev_green[44:37],
    // prev_blue[52:45], cur_red[60:53], cur_green[68:61], cur_blue[76:69]
    input  logic [lidg_pkg::S_TDATA_W-1:0]    s_tdata,
    // new_frame[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_index[12:0], out_red[20:13], out_green[28:21], out_blue[36:29]
    output logic [lidg_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lidg_pkg::*;

    logic                    dither_enable_reg;
    logic [MAX_FRAMES_W-1:0] max_dither_frames_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    clear_done;
    q_status_t               q_status;
    logic                    push, pop;
    job_t                    push_job, pop_job;
    logic                    out_ready;
    logic                    res_valid;
    result_t                 result;

    lidg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_done (clear_done),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    lidg_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    lidg_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_status          (q_status),
        .pop               (pop),
        .pop_job           (pop_job),
        .dither_enable     (dither_enable_reg),
        .max_dither_frames (max_dither_frames_reg),
        .out_ready         (out_ready),
        .res_valid         (res_valid),
        .result            (result),
        .clear_done        (clear_done)
    );

    assign out_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_enable_reg     <= DITHER_ENABLE_RST;
            max_dither_frames_reg <= MAX_DITHER_FRAMES_RST;
            m_tvalid_reg          <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DITHER_ENABLE: begin
                        dither_enable_reg <= cfg_wdata[0];
                    end
                    CFG_MAX_DITHER_FRAMES: begin
                        max_dither_frames_reg <= cfg_wdata[MAX_FRAMES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {3'b000, result.color[2], result.color[1], result.color[0],
                            result.index};
        end
    end

endmodule

>>> rtl/core/lidg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidg_front
// Accepts pixel requests, advances the frame counter and blends previous and
// current colors into 16-bit levels, one channel per cycle.
// ----------------------------------------------------------------------------
module lidg_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index[12:0], progress[28:13], prev r/g/b[52:29], cur r/g/b[76:53]
    input  logic [lidg_pkg::S_TDATA_W-1:0] s_tdata,
    // new_frame[0]
    input  logic                          s_tuser,
    input  logic                          clear_done,
    input  lidg_pkg::q_status_t           q_status,
    output logic                          push,
    output lidg_pkg::job_t                push_job
);
    import lidg_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_BLEND = 3'b010,
        F_PUSH  = 3'b100
    } front_state_t;

    front_state_t                  state_reg, state_next;
    logic [1:0]                    ch_reg, ch_next;
    logic [FRAME_W-1:0]            frame_reg, frame_next;
    logic [INDEX_W-1:0]            index_reg, index_next;
    logic [PROGRESS_W-1:0]         progress_reg, progress_next;
    logic [2:0][COLOR_W-1:0]       prev_reg, prev_next;
    logic [2:0][COLOR_W-1:0]       cur_reg, cur_next;
    logic [2:0][LEVEL_W-1:0]       level_reg, level_next;
    logic [FRAME_W-1:0]            stamp_reg, stamp_next;

    logic [COLOR_W-1:0]            p_sel, q_sel;
    logic signed [8:0]             diff;
    logic signed [25:0]            prod;
    logic signed [25:0]            sum;
    logic                          accept;

    assign s_tready = (state_reg == F_IDLE) && clear_done;
    assign accept   = s_tvalid && s_tready;

    assign p_sel = prev_reg[ch_reg];
    assign q_sel = cur_reg[ch_reg];
    assign diff  = $signed({1'b0, q_sel}) - $signed({1'b0, p_sel});
    assign prod  = $signed({{17{diff[8]}}, diff}) * $signed({9'h000, progress_reg});
    assign sum   = $signed({2'b00, p_sel, 16'h0000}) + prod;

    assign push     = (state_reg == F_PUSH) && !q_status.full;
    assign push_job = '{index: index_reg, frame: stamp_reg, level: level_reg};

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        frame_next    = frame_reg;
        index_next    = index_reg;
        progress_next = progress_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        level_next    = level_reg;
        stamp_next    = stamp_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    frame_next    = frame_reg + FRAME_W'(s_tuser);
                    stamp_next    = frame_reg + FRAME_W'(s_tuser);
                    index_next    = s_tdata[12:0];
                    progress_next = s_tdata[28:13];
                    prev_next     = {s_tdata[52:45], s_tdata[44:37], s_tdata[36:29]};
                    cur_next      = {s_tdata[76:69], s_tdata[68:61], s_tdata[60:53]};
                    ch_next       = 2'd0;
                    state_next    = F_BLEND;
                end
            end
            F_BLEND: begin
                level_next[ch_reg] = sum[23:8];
                if (ch_reg == 2'd2) begin
                    state_next = F_PUSH;
                end else begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            F_PUSH: begin
                if (!q_status.full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            frame_reg <= '0;
        end else begin
            state_reg <= state_next;
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        index_reg    <= index_next;
        progress_reg <= progress_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        level_reg    <= level_next;
        stamp_reg    <= stamp_next;
    end

endmodule

>>> rtl/core/lidg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidg_fifo
// Short queue of blended pixel jobs between the front and back parts.
// ----------------------------------------------------------------------------
module lidg_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lidg_pkg::job_t      push_job,
    input  logic                pop,
    output lidg_pkg::job_t      pop_job,
    output lidg_pkg::q_status_t q_status
);
    import lidg_pkg::*;

    job_t                   q_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] ptr);
        return (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_job        = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/lidg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidg_back
// Reads each pixel's dither word, applies the age test, the square-law curve
// and the dither rounding one channel per cycle, and writes the word back.
// ----------------------------------------------------------------------------
module lidg_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lidg_pkg::q_status_t               q_status,
    output logic                              pop,
    input  lidg_pkg::job_t                    pop_job,
    input  logic                              dither_enable,
    input  logic [lidg_pkg::MAX_FRAMES_W-1:0] max_dither_frames,
    input  logic                              out_ready,
    output logic                              res_valid,
    output lidg_pkg::result_t                 result,
    output logic                              clear_done
);
    import lidg_pkg::*;

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_GAP   = 5'b00100,
        B_CHAN  = 5'b01000,
        B_WRITE = 5'b10000
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [1:0]              ch_reg, ch_next;
    job_t                    job_reg, job_next;
    logic [2:0][7:0]         err_reg, err_next;
    logic [FRAME_W-1:0]      last_reg, last_next;
    logic                    effect_reg, effect_next;
    logic [2:0][COLOR_W-1:0] color_reg, color_next;
    logic [2:0][7:0]         nerr_reg, nerr_next;

    logic [WORD_W-1:0]       dither_ram [MAX_PIXELS];
    logic [WORD_W-1:0]       rd_data_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [WORD_W-1:0]       mem_wdata;

    logic [7:0]              last_abs, frame_abs, gap;
    logic                    too_old;

    logic [LEVEL_W-1:0]      level;
    logic [7:0]              idx, alpha;
    logic [15:0]             sq;
    logic [8:0]              slope;
    logic [16:0]             slope_prod;
    logic [15:0]             corr;
    logic [7:0]              err_eff;
    logic [16:0]             rnd, plain_rnd;
    logic [7:0]              o;

    function automatic logic [7:0] abs_s8(input logic [7:0] v);
        return v[7] ? (~v + 8'd1) : v;
    endfunction

    assign clear_done = (state_reg != B_CLEAR);

    assign last_abs  = abs_s8(rd_data_reg[31:24]);
    assign frame_abs = abs_s8(job_reg.frame);
    assign gap       = (last_abs >= frame_abs) ? last_abs - frame_abs : frame_abs - last_abs;
    assign too_old   = {{(MAX_FRAMES_W-8){1'b0}}, gap} > max_dither_frames;

    assign level      = job_reg.level[ch_reg];
    assign idx        = level[15:8];
    assign alpha      = level[7:0];
    assign sq         = {8'h00, idx} * {8'h00, idx};
    assign slope      = (idx == 8'hFF) ? LAST_SLOPE : {idx, 1'b1};
    assign slope_prod = {8'h00, slope} * {9'h000, alpha};
    assign corr       = sq + {7'h00, slope_prod[16:8]};
    assign err_eff    = dither_enable ? err_reg[ch_reg] : 8'h00;
    assign rnd        = {1'b0, corr} + {{9{err_eff[7]}}, err_eff} + 17'h00080;
    assign plain_rnd  = {1'b0, corr} + 17'h00080;
    assign o          = rnd[16] ? 8'hFF : rnd[15:8];

    assign result = '{index: job_reg.index, color: color_reg};

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        ch_next       = ch_reg;
        job_next      = job_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        effect_next   = effect_reg;
        color_next    = color_reg;
        nerr_next     = nerr_reg;
        pop           = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_raddr     = pop_job.index[ADDR_W-1:0];
        mem_wdata     = '0;
        case (state_reg)
            B_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_PIXELS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    mem_re     = 1'b1;
                    job_next   = pop_job;
                    state_next = B_GAP;
                end
            end
            B_GAP: begin
                err_next    = too_old ? '0 : rd_data_reg[23:0];
                last_next   = too_old ? job_reg.frame : rd_data_reg[31:24];
                effect_next = 1'b0;
                ch_next     = 2'd0;
                state_next  = B_CHAN;
            end
            B_CHAN: begin
                color_next[ch_reg] = o;
                nerr_next[ch_reg]  = corr[7:0] - o;
                if ({1'b0, o} != plain_rnd[16:8]) begin
                    effect_next = 1'b1;
                end
                if (ch_reg == 2'd2) begin
                    state_next = B_WRITE;
                end else begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            B_WRITE: begin
                if (out_ready) begin
                    res_valid  = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = job_reg.index[ADDR_W-1:0];
                    mem_wdata  = {(effect_reg ? job_reg.frame : last_reg), nerr_reg};
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        job_reg    <= job_next;
        err_reg    <= err_next;
        last_reg   <= last_next;
        effect_reg <= effect_next;
        color_reg  <= color_next;
        nerr_reg   <= nerr_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dither_ram[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= dither_ram[mem_raddr];
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel requests into the interpolation, gamma and dither block and
// checks every drive value against a cycle-free model of the blend, curve,
// dither error memory and frame aging. Stalls and idle gaps on both sides,
// several register settings, frame sequences over a shared set of pixels
// and random single requests.
// ----------------------------------------------------------------------------
module testbench;
    import lidg_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 205;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 300;

    typedef struct packed {
        logic [INDEX_W-1:0]          index;
        logic                        new_frame;
        logic [PROGRESS_W-1:0]       progress;
        logic [2:0][COLOR_W-1:0]     prev;
        logic [2:0][COLOR_W-1:0]     cur;
    } pixel_t;

    typedef struct packed {
        logic [INDEX_W-1:0]          index;
        logic [2:0][COLOR_W-1:0]     color;
    } drive_t;

    class pixel_scoreboard;
        bit [WORD_W-1:0]        err_mem [MAX_PIXELS];
        bit [FRAME_W-1:0]       frame_ctr;
        bit                     dither_on;
        bit [MAX_FRAMES_W-1:0]  age_limit;
        drive_t                 drive_q [$];
        int                     mismatches;

        function new();
            frame_ctr   = '0;
            dither_on   = DITHER_ENABLE_RST;
            age_limit   = MAX_DITHER_FRAMES_RST;
            mismatches  = 0;
            foreach (err_mem[i]) err_mem[i] = '0;
        endfunction

        function void note_pixel(pixel_t px);
            int unsigned inv, p, q, level, idx, alpha, pt0, pt1, corr, o, plain;
            int dith, err, last_mag, frame_mag, gap;
            bit [WORD_W-1:0] word;
            bit [FRAME_W-1:0] last;
            bit [23:0] new_err;
            bit effect;
            drive_t d;
            if (px.new_frame)
                frame_ctr = frame_ctr + 1'b1;
            word = err_mem[px.index];
            last = word[31:24];
            last_mag = $signed(last);
            frame_mag = $signed(frame_ctr);
            if (last_mag < 0) last_mag = -last_mag;
            if (frame_mag < 0) frame_mag = -frame_mag;
            gap = last_mag - frame_mag;
            if (gap < 0) gap = -gap;
            if (gap > int'(age_limit)) begin
                word = '0;
                last = frame_ctr;
            end
            inv = 32'h10000 - px.progress;
            effect = 1'b0;
            new_err = '0;
            d.index = px.index;
            for (int c = 0; c < 3; c++) begin
                p = px.prev[c];
                q = px.cur[c];
                level = ((p * inv + q * px.progress) >> 8) & 32'hFFFF;
                idx = level >> 8;
                alpha = level & 32'hFF;
                pt0 = idx * idx;
                pt1 = (idx == 255) ? 32'hFFFF : (idx + 1) * (idx + 1);
                corr = ((pt0 * (256 - alpha) + pt1 * alpha) >> 8) & 32'hFFFF;
                dith = corr;
                if (dither_on) begin
                    err = $signed(word[8*c +: 8]);
                    dith = dith + err;
                end
                o = (dith + 128) >> 8;
                if (o > 255) o = 255;
                plain = (corr + 128) >> 8;
                if (o != plain) effect = 1'b1;
                new_err[8*c +: 8] = 8'(corr - o * 257);
                d.color[c] = COLOR_W'(o);
            end
            if (effect)
                last = frame_ctr;
            err_mem[px.index] = {last, new_err};
            drive_q.push_back(d);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            drive_t got, want;
            got.index = data[INDEX_W-1:0];
            for (int c = 0; c < 3; c++)
                got.color[c] = data[INDEX_W + COLOR_W*c +: COLOR_W];
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d rgb %h %h %h", got.index,
                             got.color[0], got.color[1], got.color[2]);
            end else begin
                want = drive_q.pop_front();
                if (got.index !== want.index || got.color[0] !== want.color[0] ||
                    got.color[1] !== want.color[1] || got.color[2] !== want.color[2]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected index %0d rgb %h %h %h, got %0d rgb %h %h %h",
                                 want.index, want.color[0], want.color[1], want.color[2],
                                 got.index, got.color[0], got.color[1], got.color[2]);
                end
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_INDEX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;

    pixel_scoreboard sb;
    bit  hold_off;
    bit  quiet_send;
    int  send_count;
    int  idle_cycles;

    led_pixel_interp_gamma_dither_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [COLOR_W-1:0] random_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PROGRESS_W-1:0] random_progress();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PROGRESS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic pixel_t random_pixel(logic [INDEX_W-1:0] idx, logic nf);
        pixel_t px;
        px.index = idx;
        px.new_frame = nf;
        px.progress = random_progress();
        for (int c = 0; c < 3; c++) begin
            px.prev[c] = random_color();
            px.cur[c] = random_color();
        end
        return px;
    endfunction

    function automatic pixel_t make_pixel(logic [INDEX_W-1:0] idx, logic nf,
                                          logic [PROGRESS_W-1:0] prog,
                                          logic [23:0] prev, logic [23:0] cur);
        pixel_t px;
        px.index = idx;
        px.new_frame = nf;
        px.progress = prog;
        px.prev = prev;
        px.cur = cur;
        return px;
    endfunction

    task automatic send_pixel(pixel_t px);
        int gap;
        if (send_count % 64 == 0)
            quiet_send = ($urandom_range(0, 3) == 0);
        send_count++;
        gap = (quiet_send || hold_off) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({px.cur, px.prev, px.progress, px.index});
        s_tuser  <= px.new_frame;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_config(logic en, logic [MAX_FRAMES_W-1:0] frames);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DITHER_ENABLE;
        cfg_wdata <= CFG_DATA_W'(en);
        @(posedge aclk);
        cfg_addr  <= CFG_MAX_DITHER_FRAMES;
        cfg_wdata <= frames;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.dither_on = en;
        sb.age_limit = frames;
    endtask

    // receiver
    initial begin
        int gap;
        int results;
        bit quiet_recv;
        bit held;
        results = 0;
        held = 1'b0;
        quiet_recv = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results % 64 == 0)
                quiet_recv = ($urandom_range(0, 3) == 0);
            gap = quiet_recv ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            results++;
            if (results == HOLD_AT_RESULT && !held) begin
                held = 1'b1;
                hold_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial begin
        bit en_list [PHASES];
        int frames_list [PHASES];
        int sent, n, base, kind;
        logic [PROGRESS_W-1:0] frame_prog;
        pixel_t px;
        en_list = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        frames_list = '{8, 0, 16666, 128, 3, 127};
        sb = new();
        hold_off = 1'b0;
        quiet_send = 1'b0;
        send_count = 0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes, repeated pixel, error aging past the frame limit
        send_pixel(make_pixel(0, 1'b0, 16'h0000, 24'h000000, 24'hFFFFFF));
        send_pixel(make_pixel(0, 1'b0, 16'hFFFF, 24'h000000, 24'hFFFFFF));
        send_pixel(make_pixel(8191, 1'b1, 16'h0000, 24'hFFFFFF, 24'h000000));
        send_pixel(make_pixel(8191, 1'b0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(make_pixel(5, 1'b0, 16'h8000, 24'h80407F, 24'h01FE10));
        repeat (4) send_pixel(make_pixel(1, 1'b0, 16'h1234, 24'h030201, 24'h070605));
        send_pixel(make_pixel(4096, 1'b0, 16'h00FF, 24'h55AA55, 24'hAA55AA));
        repeat (10) send_pixel(make_pixel(2, 1'b1, 16'h4321, 24'h102030, 24'h405060));
        send_pixel(make_pixel(1, 1'b0, 16'h1234, 24'h030201, 24'h070605));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_config(en_list[ph], MAX_FRAMES_W'(frames_list[ph]));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    n = $urandom_range(1, 24);
                    base = ($urandom_range(0, 3) == 0) ? MAX_PIXELS - 24 : 0;
                    frame_prog = random_progress();
                    for (int k = 0; k < n; k++) begin
                        px = random_pixel(INDEX_W'(base + k), k == 0);
                        px.progress = frame_prog;
                        send_pixel(px);
                    end
                    sent += n;
                end else if (kind < 9) begin
                    send_pixel(random_pixel(INDEX_W'($urandom_range(0, 8191)),
                                            1'($urandom_range(0, 1))));
                    sent++;
                end else begin
                    for (int k = 0; k < 20; k++)
                        send_pixel(random_pixel(INDEX_W'($urandom_range(0, 7)), 1'b1));
                    sent += 20;
                end
            end
        end

        drain_results();
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.drive_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lidg_pkg.sv
rtl/core/lidg_front.sv
rtl/core/lidg_fifo.sv
rtl/core/lidg_back.sv
rtl/core/led_pixel_interp_gamma_dither_top.sv
test/testbench.sv
